// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/nms3_pkg.sv =====
package nms3_pkg;

  localparam int unsigned PixW     = 16;
  localparam int unsigned MaxCols  = 1024;
  localparam int unsigned MaxRows  = 4096;
  localparam int unsigned ColCntW  = $clog2(MaxCols);
  localparam int unsigned RowCntW  = $clog2(MaxRows);
  localparam int unsigned ColsW    = ColCntW + 1;
  localparam int unsigned RowsW    = RowCntW + 1;
  localparam int unsigned CfgDataW = RowsW;
  localparam int unsigned SumW     = PixW + 3;

  // floor(s / d) = (s * Recip) >> RecipShift, exact for every sum reachable with d = 3 or 5
  localparam int unsigned RecipShift = 21;
  localparam int unsigned RecipW     = 20;
  localparam int unsigned Recip3     = ((1 << RecipShift) + 2) / 3;
  localparam int unsigned Recip5     = ((1 << RecipShift) + 4) / 5;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  typedef enum logic [0:0] {
    CFG_IMAGE_ROWS = 1'b0,
    CFG_IMAGE_COLS = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_BY_3,
    DIV_BY_5,
    DIV_BY_8
  } div_sel_e;

  typedef struct packed {
    logic            drain;
    logic [PixW-1:0] pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [PixW-1:0] smoothed;
    logic            last_of_image;
  } out_beat_t;

  // which neighbour rows / columns exist for the pixel being produced
  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nbr_mask_t;

endpackage

// ===== rtl/neighbor_mean_smoothing_3x3.sv =====
// Result path: stage 1 window, stage 2 sum, stage 3 divide into the output queue.
// Throughput: 1 beat per cycle; input stall comes from a registered occupancy count of the
// two compute stages plus the 4-entry output queue, never combinationally from out_stall_i.
// Reset (async, active low): counters, window, pipeline and queue cleared, geometry 2x2;
// line stores keep whatever they hold.
module neighbor_mean_smoothing_3x3 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  nms3_pkg::in_beat_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output nms3_pkg::out_beat_t             out_data_o,
  input  logic                            cfg_we_i,
  input  nms3_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [nms3_pkg::CfgDataW-1:0]   cfg_data_i
);
  import nms3_pkg::*;

  // ---------------------------------------------------------------------------
  // Geometry registers, clamped to the legal range
  // ---------------------------------------------------------------------------
  logic [RowsW-1:0] rows_q, rows_d, rows_eff;
  logic [ColsW-1:0] cols_q, cols_d, cols_eff;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_ROWS: rows_d = cfg_data_i[RowsW-1:0];
        CFG_IMAGE_COLS: cols_d = cfg_data_i[ColsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_q < RowsW'(2))            rows_eff = RowsW'(2);
    else if (rows_q > RowsW'(MaxRows)) rows_eff = RowsW'(MaxRows);
    else                               rows_eff = rows_q;
    if (cols_q < ColsW'(2))            cols_eff = ColsW'(2);
    else if (cols_q > ColsW'(MaxCols)) cols_eff = ColsW'(MaxCols);
    else                               cols_eff = cols_q;
  end

  // ---------------------------------------------------------------------------
  // Input side: position counters
  // ---------------------------------------------------------------------------
  logic                  in_acc;
  logic [PixW-1:0]       pix;
  logic [ColCntW-1:0]    in_col_q, in_col_d;
  logic [1:0]            in_row_q, in_row_d;   // saturates at 2
  logic [ColCntW-1:0]    out_col_q, out_col_d;
  logic [RowCntW-1:0]    out_row_q, out_row_d;
  logic [ColsW-1:0]      in_col_inc, out_col_inc;
  logic [RowsW-1:0]      out_row_inc;
  logic                  emit;
  nbr_mask_t             mask;
  logic                  last;

  assign in_acc = in_valid_i && !in_stall_o;
  assign pix    = in_data_i.drain ? '0 : in_data_i.pixel_in;

  // result exists once the window has one row plus one pixel behind it
  assign emit = (in_row_q == 2'd2) || (in_row_q == 2'd1 && in_col_q != '0);

  assign in_col_inc  = {1'b0, in_col_q} + ColsW'(1);
  assign out_col_inc = {1'b0, out_col_q} + ColsW'(1);
  assign out_row_inc = {1'b0, out_row_q} + RowsW'(1);

  assign mask.up = out_row_q != '0;
  assign mask.dn = out_row_inc < rows_eff;
  assign mask.lf = out_col_q != '0;
  assign mask.rt = out_col_inc < cols_eff;
  assign last    = !mask.dn && !mask.rt;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_we_i) begin
      // new geometry starts a new image
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (in_acc) begin
      if (in_col_inc >= cols_eff) begin
        in_col_d = '0;
        if (in_row_q != 2'd2) in_row_d = in_row_q + 2'd1;
      end else begin
        in_col_d = in_col_inc[ColCntW-1:0];
      end
      if (emit) begin
        if (last) begin
          // final pixel out: next beat is pixel 0 of a fresh image
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (out_col_inc >= cols_eff) begin
          out_col_d = '0;
          out_row_d = out_row_inc[RowCntW-1:0];
        end else begin
          out_col_d = out_col_inc[ColCntW-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. Read data for the next column is prefetched on every edge, so
  // it is waiting when that column's beat arrives. The write always targets the
  // current column, which differs from the prefetched one (at least 2 columns).
  // ---------------------------------------------------------------------------
  logic [PixW-1:0] line_up_q [MaxCols];
  logic [PixW-1:0] line_lo_q [MaxCols];
  logic [PixW-1:0] up_rd_q, lo_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_up_q[in_col_q] <= lo_rd_q;
      line_lo_q[in_col_q] <= pix;
    end
    up_rd_q <= line_up_q[in_col_d];
    lo_rd_q <= line_lo_q[in_col_d];
  end

  // ---------------------------------------------------------------------------
  // 3x3 window, row-major, newest column on the right
  // ---------------------------------------------------------------------------
  logic [PixW-1:0] win_q [9];
  logic [PixW-1:0] win_d [9];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = up_rd_q;
    win_d[5] = lo_rd_q;
    win_d[8] = pix;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: captured with the window update
  // ---------------------------------------------------------------------------
  logic      v1_q;
  nbr_mask_t mask1_q;
  logic      last1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q    <= RowsW'(2);
      cols_q    <= ColsW'(2);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      v1_q      <= 1'b0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else begin
      rows_q    <= rows_d;
      cols_q    <= cols_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      v1_q      <= in_acc && emit;
      if (in_acc) begin
        for (int i = 0; i < 9; i++) win_q[i] <= win_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mask1_q <= mask;
      last1_q <= last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: masked neighbour sum, divisor choice. Runs the cycle after the
  // accept, before any following beat can shift the window twice.
  // ---------------------------------------------------------------------------
  logic [SumW-1:0] sum_d, sum_q;
  div_sel_e        sel_d, sel_q;
  logic            v2_q;
  logic            last2_q;

  always_comb begin
    sum_d = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1) &&
            !(r == 0 && !mask1_q.up) && !(r == 2 && !mask1_q.dn) &&
            !(c == 0 && !mask1_q.lf) && !(c == 2 && !mask1_q.rt)) begin
          sum_d = sum_d + SumW'(win_q[r*3+c]);
        end
      end
    end
    // 3x3 -> 8, 2x3 or 3x2 -> 5, 2x2 -> 3
    if ((mask1_q.up && mask1_q.dn) && (mask1_q.lf && mask1_q.rt)) begin
      sel_d = DIV_BY_8;
    end else if ((mask1_q.up && mask1_q.dn) || (mask1_q.lf && mask1_q.rt)) begin
      sel_d = DIV_BY_5;
    end else begin
      sel_d = DIV_BY_3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      sum_q   <= sum_d;
      sel_q   <= sel_d;
      last2_q <= last1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide by reciprocal multiply (shift for 8), result pushed into the output queue
  // ---------------------------------------------------------------------------
  logic [RecipW-1:0]      recip;
  logic [SumW+RecipW-1:0] prod;
  out_beat_t              res;

  always_comb begin
    recip = (sel_q == DIV_BY_3) ? RecipW'(Recip3) : RecipW'(Recip5);
    prod  = (SumW+RecipW)'(sum_q) * (SumW+RecipW)'(recip);
    res.last_of_image = last2_q;
    case (sel_q)
      DIV_BY_8: res.smoothed = sum_q[3 +: PixW];
      default:  res.smoothed = prod[RecipShift +: PixW];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output queue: deep enough that both compute stages can always drain into it
  // ---------------------------------------------------------------------------
  out_beat_t             fifo_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   cnt_q;
  logic [FifoCntW:0]     occ;
  logic                  push, pop;

  assign push = v2_q;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + FifoCntW'(1);
        2'b01:   cnt_q <= cnt_q - FifoCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // results queued or still in flight; one more beat must fit
  assign occ        = (FifoCntW+1)'(cnt_q) + (FifoCntW+1)'(v1_q) + (FifoCntW+1)'(v2_q);
  assign in_stall_o = occ >= (FifoCntW+1)'(FifoDepth);

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = fifo_q[rd_ptr_q];

endmodule

// ===== rtl/nms3_checker.sv =====
`include "assert_macros.svh"

module nms3_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input nms3_pkg::out_beat_t           out_data_o
);
  import nms3_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // held result stays offered and unchanged
  `ASSERT_NEXT(out_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(out_data_held, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))

  // with the output queue empty there is always room for another beat
  `ASSERT_SAME(no_stall_when_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o)

  // a newly offered result came from an accepted beat via stage 1, stage 2 and the output queue
  `ASSERT_SAME(result_has_source, clk_i, rst_ni, $rose(out_valid_o), $past(in_beat, 3))

endmodule

bind neighbor_mean_smoothing_3x3 nms3_checker u_nms3_checker (.*);
